// ----- src/spstep_pkg.sv -----
// shared types and constants for the preset position stepper core
// no dependencies
package spstep_pkg;

  // width of every configuration register
  localparam int REG_BITS = 17;
  localparam int REG_INDEX_BITS = 2;

  // parameter defaults
  localparam int PRESET_COUNT_DEFAULT = 3;
  localparam int POSITION_BITS_DEFAULT = 17;

  // reset values of the configuration registers
  localparam logic [REG_BITS-1:0] MAX_POSITION_RESET = REG_BITS'(65000);
  localparam logic [REG_BITS-1:0] PRESET_ZERO_RESET  = REG_BITS'(0);
  localparam logic [REG_BITS-1:0] PRESET_ONE_RESET   = REG_BITS'(32500);
  localparam logic [REG_BITS-1:0] PRESET_TWO_RESET   = REG_BITS'(65000);

  // configuration register indexes
  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_MAX_POSITION = 2'd0,
    REG_PRESET_ZERO  = 2'd1,
    REG_PRESET_ONE   = 2'd2,
    REG_PRESET_TWO   = 2'd3
  } reg_index_t;

  // command word kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_GOTO  = 2'd1,
    KIND_LIMIT = 2'd2,
    KIND_ZERO  = 2'd3
  } kind_t;

  // fault codes
  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_COUNT = 2'd1,
    FAULT_LIMIT = 2'd2,
    FAULT_RSVD  = 2'd3
  } fault_t;

  // preset indexes
  localparam logic [1:0] PRESET_IDX_ZERO = 2'd0;
  localparam logic [1:0] PRESET_IDX_ONE  = 2'd1;

endpackage

// ----- src/stepper_preset_position_stepper_core.sv -----
// preset position stepper core: step pulse generator with goto, limit and zero commands
// depends on spstep_pkg
//
//  channel   signals                          direction  role
//  cmd       cmd_valid cmd_stall kind          in         one command word per accept
//            preset_index
//  res       res_valid res_stall step_level    out        one result word per command
//            dir_backward drive_enabled moving
//            position fault current_preset
//  cfg       cfg_valid cfg_ready cfg_index     in         register write, always ready
//            cfg_data
//
// each command word goes through combinational next-state logic: a compare and an up/down
// count on the state registers, computed between the command and the state flops.
// the state registers are the result register; its word is shown from the cycle
// after the accept. a new command is taken every cycle while results drain.
// cmd_stall is high only while a result is held and res_stall is high.
// rst (synchronous) restores the reset state and register values, res_valid low.
module stepper_preset_position_stepper_core
  import spstep_pkg::*;
#(
  parameter int PRESET_COUNT  = PRESET_COUNT_DEFAULT,
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  // command channel
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  logic [1:0]                kind,
  input  logic [1:0]                preset_index,
  // result channel
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic                      step_level,
  output logic                      dir_backward,
  output logic                      drive_enabled,
  output logic                      moving,
  output logic [POSITION_BITS-1:0]  position,
  output logic [1:0]                fault,
  output logic [1:0]                current_preset,
  // configuration channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [REG_INDEX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]       cfg_data
);

  localparam logic [POSITION_BITS-1:0] POS_ALL_ONES = {POSITION_BITS{1'b1}};

  // configuration registers
  logic [REG_BITS-1:0] max_position;
  logic [REG_BITS-1:0] preset_zero;
  logic [REG_BITS-1:0] preset_one;
  logic [REG_BITS-1:0] preset_two;

  // motion state, also the result word
  logic [POSITION_BITS-1:0] step_position, step_position_next;
  logic [POSITION_BITS-1:0] goal_position, goal_position_next;
  logic                     going_backward, going_backward_next;
  logic                     pulse_level, pulse_level_next;
  logic                     running, running_next;
  logic                     driver_on, driver_on_next;
  fault_t                   fault_code, fault_code_next;
  logic [1:0]               chosen_preset, chosen_preset_next;

  logic                     accept;
  logic [POSITION_BITS-1:0] limit;
  logic [REG_BITS-1:0]      preset_sel;
  logic [POSITION_BITS-1:0] goal;
  logic                     index_ok;
  kind_t                    cmd_kind;

  assign cfg_ready = 1'b1;

  // hold off commands only while the result is parked
  assign cmd_stall = res_valid & res_stall;
  assign accept    = cmd_valid & ~cmd_stall;
  assign cmd_kind  = kind_t'(kind);

  // registers reduced or widened to the position count width
  assign limit = POSITION_BITS'(max_position);

  always_comb begin
    unique case (preset_index)
      PRESET_IDX_ZERO: preset_sel = preset_zero;
      PRESET_IDX_ONE:  preset_sel = preset_one;
      default:         preset_sel = preset_two;
    endcase
  end

  assign goal     = POSITION_BITS'(preset_sel);
  assign index_ok = (32'(preset_index) < PRESET_COUNT);

  always_comb begin
    step_position_next  = step_position;
    goal_position_next  = goal_position;
    going_backward_next = going_backward;
    pulse_level_next    = pulse_level;
    running_next        = running;
    driver_on_next      = driver_on;
    fault_code_next     = fault_code;
    chosen_preset_next  = chosen_preset;
    unique case (cmd_kind)
      KIND_TICK: begin
        if (running) begin
          if (!pulse_level) begin
            // rising step: count one, or trip if it would leave the travel range
            if (!going_backward) begin
              if ((step_position >= limit) || (step_position == POS_ALL_ONES)) begin
                fault_code_next = FAULT_COUNT;
                running_next    = 1'b0;
              end else begin
                step_position_next = step_position + 1'b1;
                pulse_level_next   = 1'b1;
              end
            end else begin
              if (step_position == '0) begin
                fault_code_next = FAULT_COUNT;
                running_next    = 1'b0;
              end else begin
                step_position_next = step_position - 1'b1;
                pulse_level_next   = 1'b1;
              end
            end
          end else begin
            // falling step: stop once the goal is reached
            pulse_level_next = 1'b0;
            if (step_position == goal_position) begin
              running_next = 1'b0;
            end
          end
        end
      end
      KIND_GOTO: begin
        if (index_ok) begin
          if (goal != step_position) begin
            going_backward_next = (goal < step_position);
            goal_position_next  = goal;
            driver_on_next      = 1'b1;
            running_next        = 1'b1;
          end
          chosen_preset_next = preset_index;
        end
      end
      KIND_LIMIT: begin
        running_next    = 1'b0;
        driver_on_next  = 1'b0;
        fault_code_next = FAULT_LIMIT;
      end
      KIND_ZERO: begin
        // pin level, direction and driver enable are kept
        step_position_next = '0;
        fault_code_next    = FAULT_NONE;
        running_next       = 1'b0;
      end
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_position <= MAX_POSITION_RESET;
      preset_zero  <= PRESET_ZERO_RESET;
      preset_one   <= PRESET_ONE_RESET;
      preset_two   <= PRESET_TWO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_MAX_POSITION: max_position <= cfg_data;
        REG_PRESET_ZERO:  preset_zero  <= cfg_data;
        REG_PRESET_ONE:   preset_one   <= cfg_data;
        REG_PRESET_TWO:   preset_two   <= cfg_data;
        default: ;
      endcase
    end
  end

  // motion state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      step_position  <= '0;
      goal_position  <= '0;
      going_backward <= 1'b0;
      pulse_level    <= 1'b0;
      running        <= 1'b0;
      driver_on      <= 1'b1;
      fault_code     <= FAULT_NONE;
      chosen_preset  <= PRESET_IDX_ZERO;
      res_valid      <= 1'b0;
    end else begin
      if (accept) begin
        step_position  <= step_position_next;
        goal_position  <= goal_position_next;
        going_backward <= going_backward_next;
        pulse_level    <= pulse_level_next;
        running        <= running_next;
        driver_on      <= driver_on_next;
        fault_code     <= fault_code_next;
        chosen_preset  <= chosen_preset_next;
        res_valid      <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign step_level     = pulse_level;
  assign dir_backward   = going_backward;
  assign drive_enabled  = driver_on;
  assign moving         = running;
  assign position       = step_position;
  assign fault          = fault_code;
  assign current_preset = chosen_preset;

endmodule
